// File: sv/tpns_pkg.sv
package tpns_pkg;

    typedef enum logic [1:0] {
        REQ_ADD     = 2'd0,
        REQ_REMOVE  = 2'd1,
        REQ_NEAREST = 2'd2,
        REQ_COUNT   = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic rd_en;
        logic clr;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic pipe_idle;
        logic out_free;
    } t_status;

    localparam logic [8:0]  CNT_MAX           = 9'h1FF;
    localparam logic        REG_SEARCH_RADIUS = 1'b0;
    localparam logic [15:0] RADIUS_RESET      = 16'd1000;

endpackage

// File: sv/tpns_ctrl.sv
module tpns_ctrl #(
    parameter int TABLE_ENTRIES = 256,
    parameter int AW            = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  tpns_pkg::t_status i_status,
    output tpns_pkg::t_cmd    o_cmd,
    output logic [AW-1:0]    o_addr
);
    import tpns_pkg::*;

    localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_ENTRIES - 1);

    t_state        r_state;
    t_state        n_state;
    logic [AW-1:0] r_addr;
    logic [AW-1:0] n_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_addr  <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_addr == LAST_ADDR) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (r_addr == LAST_ADDR) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (i_status.pipe_idle) n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        n_addr     = r_addr;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr = 1'b1;
                n_addr    = (r_addr == LAST_ADDR) ? '0 : r_addr + 1'b1;
            end
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
                n_addr     = '0;
            end
            ST_SCAN: begin
                o_cmd.rd_en = 1'b1;
                n_addr      = (r_addr == LAST_ADDR) ? '0 : r_addr + 1'b1;
            end
            ST_DRAIN: begin
                n_addr = '0;
            end
            ST_FINISH: begin
                o_cmd.finish = i_status.out_free;
            end
            default: begin
                n_addr = '0;
            end
        endcase
    end

    assign o_addr = r_addr;

endmodule

// File: sv/tpns_dp.sv
module tpns_dp #(
    parameter int TABLE_ENTRIES = 256,
    parameter int AW            = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tpns_pkg::t_cmd      i_cmd,
    input  logic [AW-1:0]       i_addr,
    output tpns_pkg::t_status   o_status,
    input  logic [15:0]         i_radius,
    input  logic [1:0]          i_req_type,
    input  logic [3:0]          i_entry_type,
    input  logic signed [15:0]  i_pos_x,
    input  logic signed [15:0]  i_pos_y,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic signed [15:0]  o_found_x,
    output logic signed [15:0]  o_found_y,
    output logic [8:0]          o_type_count,
    output logic                o_done_ok
);
    import tpns_pkg::*;

    logic [3:0]  r_mem_type [TABLE_ENTRIES];
    logic [15:0] r_mem_x    [TABLE_ENTRIES];
    logic [15:0] r_mem_y    [TABLE_ENTRIES];

    t_req        r_req;
    logic [3:0]  r_typ;
    logic [15:0] r_qx;
    logic [15:0] r_qy;
    logic [31:0] r_rad2;

    logic          r_v1;
    logic [AW-1:0] r_idx1;
    logic [3:0]    r_t1;
    logic [15:0]   r_x1;
    logic [15:0]   r_y1;

    logic        r_v2;
    logic        r_first2;
    logic        r_match2;
    logic [31:0] r_dx2;
    logic [31:0] r_dy2;
    logic [15:0] r_x2;
    logic [15:0] r_y2;

    logic [32:0]   r_best;
    logic [15:0]   r_bx;
    logic [15:0]   r_by;
    logic [8:0]    r_cnt;
    logic          r_have_empty;
    logic [AW-1:0] r_empty_idx;

    logic        r_out_valid;
    logic [15:0] r_fx;
    logic [15:0] r_fy;
    logic [8:0]  r_cnt_out;
    logic        r_ok;

    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic signed [33:0] dx_sq;
    logic signed [33:0] dy_sq;
    logic [32:0]        sq_dist;
    logic               take_out;
    logic               rm_hit;
    logic               add_wr;

    logic          wr_type;
    logic          wr_pos;
    logic [AW-1:0] wr_addr;
    logic [3:0]    wr_t;
    logic [15:0]   wr_x;
    logic [15:0]   wr_y;

    assign take_out = r_out_valid && !i_out_stall;
    assign o_status.pipe_idle = !r_v1 && !r_v2;
    assign o_status.out_free  = !r_out_valid || !i_out_stall;

    assign rm_hit = r_v1 && (r_req == REQ_REMOVE) && (r_x1 == r_qx) && (r_y1 == r_qy);
    assign add_wr = i_cmd.finish && (r_req == REQ_ADD) && r_have_empty;

    always_comb begin
        wr_type = 1'b0;
        wr_pos  = 1'b0;
        wr_addr = i_addr;
        wr_t    = 4'd0;
        wr_x    = 16'd0;
        wr_y    = 16'd0;
        if (i_cmd.clr) begin
            wr_type = 1'b1;
            wr_pos  = 1'b1;
        end else if (add_wr) begin
            wr_type = 1'b1;
            wr_pos  = 1'b1;
            wr_addr = r_empty_idx;
            wr_t    = r_typ;
            wr_x    = r_qx;
            wr_y    = r_qy;
        end else if (rm_hit) begin
            wr_type = 1'b1;
            wr_addr = r_idx1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_type) r_mem_type[wr_addr] <= wr_t;
        if (wr_pos) begin
            r_mem_x[wr_addr] <= wr_x;
            r_mem_y[wr_addr] <= wr_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_t1 <= r_mem_type[i_addr];
            r_x1 <= r_mem_x[i_addr];
            r_y1 <= r_mem_y[i_addr];
        end
        r_idx1 <= i_addr;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req  <= t_req'(i_req_type);
            r_typ  <= i_entry_type;
            r_qx   <= i_pos_x;
            r_qy   <= i_pos_y;
            r_rad2 <= i_radius * i_radius;
        end
    end

    assign dx    = $signed({r_x1[15], r_x1}) - $signed({r_qx[15], r_qx});
    assign dy    = $signed({r_y1[15], r_y1}) - $signed({r_qy[15], r_qy});
    assign dx_sq = dx * dx;
    assign dy_sq = dy * dy;

    always_ff @(posedge i_clk) begin
        r_first2 <= (r_idx1 == '0);
        r_match2 <= (r_t1 == r_typ);
        r_dx2    <= dx_sq[31:0];
        r_dy2    <= dy_sq[31:0];
        r_x2     <= r_x1;
        r_y2     <= r_y1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.rd_en;
            r_v2 <= r_v1;
        end
    end

    assign sq_dist = {1'b0, r_dx2} + {1'b0, r_dy2};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cnt        <= '0;
            r_have_empty <= 1'b0;
        end else if (r_v1) begin
            if (r_t1 == r_typ && r_cnt != CNT_MAX) r_cnt <= r_cnt + 1'b1;
            if (r_t1 == 4'd0 && !r_have_empty) begin
                r_have_empty <= 1'b1;
                r_empty_idx  <= r_idx1;
            end
        end
        if (r_v2) begin
            if (r_first2) begin
                r_bx   <= r_x2;
                r_by   <= r_y2;
                r_best <= (r_match2 && sq_dist < {1'b0, r_rad2}) ? sq_dist : {1'b0, r_rad2};
            end else if (r_match2 && sq_dist < r_best) begin
                r_bx   <= r_x2;
                r_by   <= r_y2;
                r_best <= sq_dist;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (take_out) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            case (r_req)
                REQ_ADD: begin
                    r_fx      <= 16'd0;
                    r_fy      <= 16'd0;
                    r_cnt_out <= 9'd0;
                    r_ok      <= r_have_empty;
                end
                REQ_NEAREST: begin
                    r_fx      <= r_bx;
                    r_fy      <= r_by;
                    r_cnt_out <= 9'd0;
                    r_ok      <= 1'b1;
                end
                REQ_COUNT: begin
                    r_fx      <= 16'd0;
                    r_fy      <= 16'd0;
                    r_cnt_out <= r_cnt;
                    r_ok      <= 1'b1;
                end
                default: begin
                    r_fx      <= 16'd0;
                    r_fy      <= 16'd0;
                    r_cnt_out <= 9'd0;
                    r_ok      <= 1'b1;
                end
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_found_x    = r_fx;
    assign o_found_y    = r_fy;
    assign o_type_count = r_cnt_out;
    assign o_done_ok    = r_ok;

endmodule

// File: sv/typed_point_table_nearest_search.sv
// Each request scans every table entry, one per cycle through the single read port
// of the table memory, then waits for the pipeline to drain and registers the result.
// One request is in work at a time; a stalled result holds back the next one. After
// reset a clearing pass writes every entry to empty, during which no request is taken;
// the search radius resets to 1000.
module typed_point_table_nearest_search #(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_req_type,
    input  logic [3:0]         i_entry_type,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_found_x,
    output logic signed [15:0] o_found_y,
    output logic [8:0]         o_type_count,
    output logic               o_done_ok
);
    import tpns_pkg::*;

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    logic [15:0]   r_radius;
    t_cmd          cmd;
    t_status       status;
    logic [AW-1:0] addr;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SEARCH_RADIUS) ? {16'd0, r_radius} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_SEARCH_RADIUS) begin
            r_radius <= pwdata[15:0];
        end
    end

    tpns_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .AW            (AW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_addr     (addr)
    );

    tpns_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .AW            (AW)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_addr       (addr),
        .o_status     (status),
        .i_radius     (r_radius),
        .i_req_type   (i_req_type),
        .i_entry_type (i_entry_type),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_found_x    (o_found_x),
        .o_found_y    (o_found_y),
        .o_type_count (o_type_count),
        .o_done_ok    (o_done_ok)
    );

endmodule

// File: verif/tpns_checker.sv
`timescale 1ns / 100ps

module tpns_checker #(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic               i_pready,
    input  logic [2:0]         i_paddr,
    input  logic [31:0]        i_pwdata,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [1:0]         i_req_type,
    input  logic [3:0]         i_entry_type,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [15:0] i_found_x,
    input  logic signed [15:0] i_found_y,
    input  logic [8:0]         i_type_count,
    input  logic               i_done_ok,
    output int                 o_fail_count,
    output int                 o_pending
);
    import tpns_pkg::*;

    typedef struct packed {
        logic signed [15:0] fx;
        logic signed [15:0] fy;
        logic [8:0]         cnt;
        logic               ok;
    } t_answer;

    logic [3:0]         kind_tbl [TABLE_ENTRIES];
    logic signed [15:0] x_tbl    [TABLE_ENTRIES];
    logic signed [15:0] y_tbl    [TABLE_ENTRIES];
    logic [15:0]        radius;
    t_answer            pending_answers [$];
    int                 failures = 0;

    function automatic t_answer run_table_request(input t_req req, input logic [3:0] kind,
                                                  input logic signed [15:0] qx,
                                                  input logic signed [15:0] qy);
        t_answer ans;
        longint  best;
        longint  sq_dist;
        longint  dx;
        longint  dy;
        int      pick;
        ans = '{fx: 16'sd0, fy: 16'sd0, cnt: 9'd0, ok: 1'b1};
        case (req)
            REQ_ADD: begin
                ans.ok = 1'b0;
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    if (!ans.ok && kind_tbl[i] == 4'd0) begin
                        kind_tbl[i] = kind;
                        x_tbl[i]    = qx;
                        y_tbl[i]    = qy;
                        ans.ok      = 1'b1;
                    end
                end
            end
            REQ_REMOVE: begin
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    if (x_tbl[i] == qx && y_tbl[i] == qy) begin
                        kind_tbl[i] = 4'd0;
                    end
                end
            end
            REQ_NEAREST: begin
                best = longint'(radius) * longint'(radius);
                pick = 0;
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    if (kind_tbl[i] == kind) begin
                        dx      = longint'(qx) - longint'(x_tbl[i]);
                        dy      = longint'(qy) - longint'(y_tbl[i]);
                        sq_dist = dx * dx + dy * dy;
                        if (sq_dist < best) begin
                            best = sq_dist;
                            pick = i;
                        end
                    end
                end
                ans.fx = x_tbl[pick];
                ans.fy = y_tbl[pick];
            end
            default: begin
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    if (kind_tbl[i] == kind && ans.cnt != CNT_MAX) begin
                        ans.cnt = ans.cnt + 9'd1;
                    end
                end
            end
        endcase
        return ans;
    endfunction

    always @(posedge i_clk) begin : watch
        t_answer got;
        t_answer want;
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                kind_tbl[i] = 4'd0;
                x_tbl[i]    = 16'sd0;
                y_tbl[i]    = 16'sd0;
            end
            radius = RADIUS_RESET;
            pending_answers.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready
                && i_paddr == {REG_SEARCH_RADIUS, 2'b00}) begin
                radius = i_pwdata[15:0];
            end
            if (i_out_valid && !i_out_stall) begin
                got = '{fx: i_found_x, fy: i_found_y, cnt: i_type_count, ok: i_done_ok};
                if (pending_answers.size() == 0) begin
                    failures++;
                    if (failures <= 10) begin
                        $display("%0t: unexpected result x=%0d y=%0d count=%0d ok=%0b",
                                 $realtime, got.fx, got.fy, got.cnt, got.ok);
                    end
                end else begin
                    want = pending_answers.pop_front();
                    if (got !== want) begin
                        failures++;
                        if (failures <= 10) begin
                            $display("%0t: mismatch expected x=%0d y=%0d count=%0d ok=%0b",
                                     $realtime, want.fx, want.fy, want.cnt, want.ok);
                            $display("%0t:          actual   x=%0d y=%0d count=%0d ok=%0b",
                                     $realtime, got.fx, got.fy, got.cnt, got.ok);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                pending_answers.push_back(run_table_request(t_req'(i_req_type), i_entry_type,
                                                            i_pos_x, i_pos_y));
            end
        end
        o_fail_count <= failures;
        o_pending    <= pending_answers.size();
    end

endmodule

// File: verif/tb_typed_point_table_nearest_search.sv
`timescale 1ns / 100ps

module tb_typed_point_table_nearest_search;
    import tpns_pkg::*;

    localparam int         TABLE_ENTRIES = 256;
    localparam logic [2:0] ADDR_RADIUS   = {REG_SEARCH_RADIUS, 2'b00};
    localparam logic [2:0] ADDR_UNUSED   = 3'd4;

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               psel         = 1'b0;
    logic               penable      = 1'b0;
    logic               pwrite       = 1'b0;
    logic [2:0]         paddr        = 3'd0;
    logic [31:0]        pwdata       = 32'd0;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_in_valid   = 1'b0;
    logic               o_in_stall;
    logic [1:0]         i_req_type   = 2'd0;
    logic [3:0]         i_entry_type = 4'd0;
    logic signed [15:0] i_pos_x      = 16'sd0;
    logic signed [15:0] i_pos_y      = 16'sd0;
    logic               o_out_valid;
    logic               i_out_stall  = 1'b0;
    logic signed [15:0] o_found_x;
    logic signed [15:0] o_found_y;
    logic [8:0]         o_type_count;
    logic               o_done_ok;

    int                 fail_count;
    int                 pending;
    bit                 in_gaps_on   = 1'b1;
    bit                 out_gaps_on  = 1'b1;
    logic signed [15:0] pool_x [64];
    logic signed [15:0] pool_y [64];

    typed_point_table_nearest_search #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_req_type  (i_req_type),
        .i_entry_type(i_entry_type),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_found_x   (o_found_x),
        .o_found_y   (o_found_y),
        .o_type_count(o_type_count),
        .o_done_ok   (o_done_ok)
    );

    tpns_checker #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_pready    (pready),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_req_type  (i_req_type),
        .i_entry_type(i_entry_type),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_found_x   (o_found_x),
        .i_found_y   (o_found_y),
        .i_type_count(o_type_count),
        .i_done_ok   (o_done_ok),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("tb: failure");
        $finish;
    end

    // At times the result side holds stall over the arrival of a result, for a hold drawn at random.
    initial begin : result_sink
        int hold;
        forever begin
            hold = out_gaps_on ? $urandom_range(0, 18) : 0;
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                @(posedge i_clk);
                while (!o_out_valid) @(posedge i_clk);
                repeat (hold - 1) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    task automatic send_request(input t_req req, input logic [3:0] kind,
                                input logic signed [15:0] x, input logic signed [15:0] y);
        int gap;
        gap = in_gaps_on ? $urandom_range(0, 18) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_req_type   <= req;
        i_entry_type <= kind;
        i_pos_x      <= x;
        i_pos_y      <= y;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic run_phase(input int n, input int add_pct, input int remove_pct,
                             input int nearest_pct);
        int                 roll;
        int                 p;
        t_req               req;
        logic [3:0]         kind;
        logic signed [15:0] x;
        logic signed [15:0] y;
        for (int k = 0; k < n; k++) begin
            if (k % 50 == 0) begin
                in_gaps_on  = ($urandom_range(0, 3) != 0);
                out_gaps_on = ($urandom_range(0, 3) != 0);
            end
            roll = $urandom_range(0, 99);
            if (roll < add_pct) begin
                req = REQ_ADD;
            end else if (roll < add_pct + remove_pct) begin
                req = REQ_REMOVE;
            end else if (roll < add_pct + remove_pct + nearest_pct) begin
                req = REQ_NEAREST;
            end else begin
                req = REQ_COUNT;
            end
            kind = ($urandom_range(0, 9) < 6) ? 4'($urandom_range(1, 4)) : 4'($urandom);
            p    = $urandom_range(0, 63);
            roll = $urandom_range(0, 9);
            if (roll < 5) begin
                x = pool_x[p];
                y = pool_y[p];
            end else if (roll < 8) begin
                x = pool_x[p] + 16'($urandom_range(0, 1200) - 600);
                y = pool_y[p] + 16'($urandom_range(0, 1200) - 600);
            end else begin
                x = 16'($urandom);
                y = 16'($urandom);
            end
            send_request(req, kind, x, y);
        end
    endtask

    initial begin : stimulus
        for (int i = 0; i < 64; i++) begin
            pool_x[i] = 16'($urandom);
            pool_y[i] = 16'($urandom);
        end
        pool_x[0] = 16'sh7FFF;
        pool_y[0] = 16'sh8000;
        pool_x[1] = 16'sh8000;
        pool_y[1] = 16'sh7FFF;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_request(REQ_COUNT,   4'd0,  16'sd0,      16'sd0);
        send_request(REQ_NEAREST, 4'd0,  16'sd0,      16'sd0);
        send_request(REQ_NEAREST, 4'd9,  16'sd5,      16'sd5);
        send_request(REQ_ADD,     4'd5,  16'sh7FFF,   16'sh8000);
        send_request(REQ_ADD,     4'd5,  16'sh8000,   16'sh7FFF);
        send_request(REQ_ADD,     4'd0,  16'sd123,    -16'sd45);
        send_request(REQ_NEAREST, 4'd0,  16'sd120,    -16'sd40);
        send_request(REQ_ADD,     4'd15, 16'sd100,    16'sd100);
        send_request(REQ_ADD,     4'd15, 16'sd103,    16'sd104);
        send_request(REQ_ADD,     4'd7,  16'sd10,     16'sd0);
        send_request(REQ_ADD,     4'd7,  -16'sd10,    16'sd0);
        send_request(REQ_NEAREST, 4'd7,  16'sd0,      16'sd0);
        send_request(REQ_NEAREST, 4'd15, 16'sd102,    16'sd102);
        send_request(REQ_NEAREST, 4'd5,  16'sh8000,   16'sh8000);
        send_request(REQ_COUNT,   4'd15, 16'sd0,      16'sd0);
        send_request(REQ_COUNT,   4'd5,  16'sd0,      16'sd0);
        send_request(REQ_REMOVE,  4'd3,  16'sd100,    16'sd100);
        send_request(REQ_REMOVE,  4'd0,  16'sd0,      16'sd0);
        send_request(REQ_NEAREST, 4'd15, 16'sd100,    16'sd100);
        drain_results();
        write_register(ADDR_RADIUS, 32'd0);
        send_request(REQ_NEAREST, 4'd15, 16'sd103,    16'sd104);
        drain_results();
        write_register(ADDR_RADIUS, 32'd65535);
        send_request(REQ_NEAREST, 4'd15, -16'sd30000, -16'sd30000);
        drain_results();
        write_register(ADDR_UNUSED, 32'd3);
        send_request(REQ_NEAREST, 4'd15, -16'sd30000, -16'sd30000);
        send_request(REQ_COUNT,   4'd0,  16'sd0,      16'sd0);
        send_request(REQ_REMOVE,  4'd1,  16'sh8000,   16'sh7FFF);
        drain_results();

        write_register(ADDR_RADIUS, 32'd1000);
        run_phase(400, 85, 3, 8);
        drain_results();
        write_register(ADDR_RADIUS, 32'd65535);
        run_phase(180, 40, 20, 30);
        drain_results();
        write_register(ADDR_RADIUS, 32'd0);
        run_phase(150, 30, 20, 35);
        drain_results();
        write_register(ADDR_RADIUS, 32'($urandom_range(1, 2000)));
        run_phase(220, 35, 25, 30);
        drain_results();
        write_register(ADDR_RADIUS, 32'd50);
        run_phase(200, 50, 15, 25);
        drain_results();
        write_register(ADDR_RADIUS, 32'($urandom_range(0, 65535)));
        run_phase(200, 40, 20, 30);
        drain_results();

        repeat (300) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
